>>> design/sqwdec_pkg.sv
// Shared types, constants and the duty table of the square-wave channel.
`timescale 1ns / 1ps

package sqwdec_pkg;

    // Item kinds carried in s_tuser
    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_TICK  = 2'd2
    } mode_t;

    // Register addresses
    localparam logic [15:0] ADDR_CTRL   = 16'h4000;
    localparam logic [15:0] ADDR_TLO    = 16'h4002;
    localparam logic [15:0] ADDR_THI    = 16'h4003;
    localparam logic [15:0] ADDR_STATUS = 16'h4015;

    localparam logic [12:0] AMP_STEP    = 13'd400;
    localparam logic [10:0] MIN_AUDIBLE = 11'd8;

    // Decimator constants, in hundredths of a CPU cycle
    localparam logic [13:0] TICK_STEP           = 14'd100;
    localparam logic [12:0] PERIOD_MIN          = 13'd100;
    localparam logic [12:0] SAMPLE_PERIOD_RESET = 13'd4058;

    // Channel result handed to the output stage
    typedef struct packed {
        logic        read_data;
        logic [13:0] sample;
    } chan_result_t;

    // Duty waveform: bit n of each pattern is step n of the sequence
    function automatic logic duty_level(input logic [1:0] duty, input logic [2:0] phase);
        logic [7:0] pattern;
        case (duty)
            2'd0:    pattern = 8'b0000_0010;
            2'd1:    pattern = 8'b0000_0110;
            2'd2:    pattern = 8'b0001_1110;
            default: pattern = 8'b1111_1001;
        endcase
        return pattern[phase];
    endfunction

endpackage

>>> design/square_wave_channel_with_decimator_core.sv
// Top level of the square-wave channel with output decimator.
//
//  channel  | dir | tdata (low bit up)                        | tuser
//  s_       | in  | address[15:0], write_data[23:16]          | mode[1:0]
//  m_       | out | read_data[0], sample[14:1], zero[15]      | sample_valid[0]
//  cfg_wr_  | in  | sample_period_hundredths[12:0]            | -
//
// One request is accepted per clock while s_tready is high; its result is
// registered and shows in the next cycle. All state updates in the accepting cycle.
// Reset: aresetn low clears all channel state, the decimator and the result
// slot, and loads the sample period with 4058.
// Stalls: a held result blocks new requests only while m_tready is low.
`timescale 1ns / 1ps

module square_wave_channel_with_decimator_core import sqwdec_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // read_data[0], sample[14:1], zero[15]
    output logic [0:0]  m_tuser    // sample_valid[0]
);

    logic         accept;
    logic         fire;
    logic         free;
    chan_result_t result;

    assign s_tready = free;
    assign accept   = s_tvalid && free;

    sqwdec_chan u_chan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .mode       (s_tuser),
        .address    (s_tdata[15:0]),
        .write_data (s_tdata[23:16]),
        .result     (result)
    );

    sqwdec_decim u_decim (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tick        (accept && (s_tuser == MODE_TICK)),
        .fire        (fire)
    );

    sqwdec_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .result   (result),
        .fire     (fire),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> design/sqwdec_chan.sv
// Pulse channel registers, period timer, duty sequencer and sample level.
`timescale 1ns / 1ps

module sqwdec_chan import sqwdec_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         accept,
    input  logic [1:0]   mode,
    input  logic [15:0]  address,
    input  logic [7:0]   write_data,
    output chan_result_t result
);

    logic [1:0]  duty_reg,    duty_next;
    logic [3:0]  volume_reg,  volume_next;
    logic [10:0] reload_reg,  reload_next;
    logic [10:0] counter_reg, counter_next;
    logic [2:0]  phase_reg,   phase_next;
    logic        enable_reg,  enable_next;

    logic        audible;
    logic [12:0] mag;

    // Register writes and timer step
    always_comb begin
        duty_next    = duty_reg;
        volume_next  = volume_reg;
        reload_next  = reload_reg;
        counter_next = counter_reg;
        phase_next   = phase_reg;
        enable_next  = enable_reg;
        if (accept) begin
            case (mode)
                MODE_WRITE: begin
                    if (address == ADDR_CTRL) begin
                        duty_next   = write_data[7:6];
                        volume_next = write_data[3:0];
                    end else if (address == ADDR_TLO) begin
                        reload_next = {reload_reg[10:8], write_data};
                    end else if (address == ADDR_THI) begin
                        reload_next = {write_data[2:0], reload_reg[7:0]};
                        phase_next  = 3'd0;
                    end else if (address == ADDR_STATUS) begin
                        enable_next = write_data[0];
                        if (!write_data[0]) begin
                            reload_next = 11'd0;
                        end
                    end
                end
                MODE_TICK: begin
                    if (counter_reg != 11'd0) begin
                        counter_next = counter_reg - 11'd1;
                    end else begin
                        counter_next = reload_reg;
                        phase_next   = phase_reg + 3'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg    <= 2'd0;
            volume_reg  <= 4'd0;
            reload_reg  <= 11'd0;
            counter_reg <= 11'd0;
            phase_reg   <= 3'd0;
            enable_reg  <= 1'b0;
        end else begin
            duty_reg    <= duty_next;
            volume_reg  <= volume_next;
            reload_reg  <= reload_next;
            counter_reg <= counter_next;
            phase_reg   <= phase_next;
            enable_reg  <= enable_next;
        end
    end

    // Status read and signed sample level from the updated phase
    assign audible = enable_reg && (reload_reg > MIN_AUDIBLE);
    assign mag     = 13'(volume_reg) * AMP_STEP;

    always_comb begin
        result.read_data = (mode == MODE_READ) && (address == ADDR_STATUS)
                           && (reload_reg != 11'd0);
        if (!audible) begin
            result.sample = 14'd0;
        end else if (duty_level(duty_reg, phase_next)) begin
            result.sample = {1'b0, mag};
        end else begin
            result.sample = 14'd0 - {1'b0, mag};
        end
    end

    // Disabling the channel clears the period
    a_disable_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && mode == MODE_WRITE && address == ADDR_STATUS && !write_data[0])
        |=> (reload_reg == 11'd0 && !enable_reg))
        else $error("period not cleared on disable");

    // High period write restarts the duty sequence
    a_thi_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && mode == MODE_WRITE && address == ADDR_THI) |=> (phase_reg == 3'd0))
        else $error("phase not reset on high period write");

    // A running timer only counts down, the phase holds
    a_tick_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && mode == MODE_TICK && counter_reg != 11'd0)
        |=> (counter_reg == $past(counter_reg) - 11'd1 && $stable(phase_reg)))
        else $error("timer step wrong");

endmodule

>>> design/sqwdec_decim.sv
// Fractional sample decimator counting in hundredths of a CPU cycle.
`timescale 1ns / 1ps

module sqwdec_decim import sqwdec_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [12:0] cfg_wr_data,
    input  logic        tick,
    output logic        fire
);

    logic [12:0] period_reg;
    logic [12:0] accum_reg, accum_next;
    logic [12:0] per;
    logic [13:0] sum;

    // Clamp the period so at most one sample per tick
    assign per = (period_reg < PERIOD_MIN) ? PERIOD_MIN : period_reg;
    assign sum = {1'b0, accum_reg} + TICK_STEP;

    always_comb begin
        fire       = 1'b0;
        accum_next = accum_reg;
        if (tick) begin
            if (sum >= {1'b0, per}) begin
                fire       = 1'b1;
                accum_next = 13'(sum - {1'b0, per});
            end else begin
                accum_next = sum[12:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= SAMPLE_PERIOD_RESET;
            accum_reg  <= 13'd0;
        end else begin
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
            accum_reg <= accum_next;
        end
    end

endmodule

>>> design/sqwdec_out.sv
// Result register holding one finished request for the master side.
`timescale 1ns / 1ps

module sqwdec_out import sqwdec_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         load,
    input  chan_result_t result,
    input  logic         fire,
    output logic         free,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,
    output logic [0:0]   m_tuser
);

    logic        valid_reg;
    logic        read_reg;
    logic        svalid_reg;
    logic [13:0] sample_reg;

    // Take a new result whenever the slot is empty or being drained
    assign free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload, sample zeroed when no sample is due
    always_ff @(posedge aclk) begin
        if (load) begin
            read_reg   <= result.read_data;
            svalid_reg <= fire;
            sample_reg <= fire ? result.sample : 14'd0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, sample_reg, read_reg};
    assign m_tuser  = svalid_reg;

endmodule
